>>> sv/mau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_pkg
// shared types, codes and constants of the modular arithmetic unit
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 62;
  localparam logic [61:0] RESET_MODULUS = 62'd1000000007;

  // operation codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_POW = 3'd3;
  localparam logic [2:0] OP_INV = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [61:0] operand_a;
    logic [63:0] operand_b;
  } request_t;

  typedef struct packed {
    logic [61:0] result_value;
    logic        no_inverse;
  } result_t;

  typedef enum logic [1:0] {
    DIV_A = 2'd0,
    DIV_B = 2'd1,
    DIV_R = 2'd2
  } div_sel_t;

  typedef enum logic [1:0] {
    MUL_AB        = 2'd0,
    MUL_ACC_BASE  = 2'd1,
    MUL_BASE_BASE = 2'd2,
    MUL_Q_T1      = 2'd3
  } mul_sel_t;

  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_STORE_A  = 4'd1,
    ACT_STORE_B  = 4'd2,
    ACT_ADD      = 4'd3,
    ACT_SUB      = 4'd4,
    ACT_MUL_RES  = 4'd5,
    ACT_POW_INIT = 4'd6,
    ACT_POW_ACC  = 4'd7,
    ACT_POW_BASE = 4'd8,
    ACT_POW_FIN  = 4'd9,
    ACT_INV_INIT = 4'd10,
    ACT_INV_Q    = 4'd11,
    ACT_INV_STEP = 4'd12,
    ACT_INV_FIN  = 4'd13,
    ACT_ZERO     = 4'd14
  } act_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     mul_start;
    mul_sel_t mul_sel;
    act_t     act;
  } dp_cmd_t;

  typedef struct packed {
    logic       div_busy;
    logic       mul_busy;
    logic [2:0] op;
    logic       m_small;
    logic       exp_zero;
    logic       exp_lsb;
    logic       r1_zero;
  } dp_status_t;

endpackage

>>> sv/modular_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// add, subtract, multiply, power and inverse modulo a programmable modulus
// ----------------------------------------------------------------------------
//  channel   signals                               direction  handshake
//  request   start, busy, request                  in         start && !busy
//  result    done, result                          out        done (one cycle)
//  config    psel, penable, pwrite, paddr, pwdata,  in         apb, modulus at 0
//            prdata, pready
//
//  one word in flight at a time; busy is high from acceptance until done
//  work is done by a restoring divider over 64 quotient bits and a bit-serial
//  modular multiplier (a doubling and a conditional-add phase per bit); every
//  operation first reduces operand a, add/sub/multiply also reduce operand b,
//  power squares once per exponent bit and multiplies once per set bit, and
//  inverse runs one division and one multiplication per euclid step
//  reset is synchronous; modulus returns to 1000000007, no clearing pass
//  done is a one-cycle strobe; the receiver always takes the word
// ----------------------------------------------------------------------------
module modular_arithmetic_unit #(
  parameter int VALUE_WIDTH = mau_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              start,
  output logic              busy,
  input  mau_pkg::request_t request,
  // result channel
  output logic              done,
  output mau_pkg::result_t  result,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  localparam logic [61:0] RESET_FULL = mau_pkg::RESET_MODULUS;

  logic [VALUE_WIDTH-1:0] modulus;
  logic [VALUE_WIDTH-1:0] res_value;
  logic                   res_flag;
  mau_pkg::dp_cmd_t       cmd;
  mau_pkg::dp_status_t    status;

  // modulus register, only address zero holds a register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= RESET_FULL[VALUE_WIDTH-1:0];
    end else if (psel && penable && pwrite && pready && !paddr) begin
      modulus <= pwdata[VALUE_WIDTH-1:0];
    end
  end

  assign prdata = paddr ? 64'd0 : 64'(modulus);

  mau_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mau_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .modulus   (modulus),
    .request   (request),
    .cmd       (cmd),
    .status    (status),
    .res_value (res_value),
    .res_flag  (res_flag)
  );

  // result word straight from the datapath result registers
  assign result.result_value = 62'(res_value);
  assign result.no_inverse   = res_flag;

  // done is always followed by an idle cycle
  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy after done");

  // an accepted word makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accept did not raise busy");

  // a failed inverse reports zero
  a_noinv_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res_flag) |-> (res_value == '0))
    else $error("no_inverse with nonzero value");

  // result is reduced
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    (done && modulus >= VALUE_WIDTH'(2)) |-> (res_value < modulus))
    else $error("result not below modulus");

endmodule

>>> sv/mau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_datapath
// operand registers, bit-serial divider and bit-serial modular multiplier
// ----------------------------------------------------------------------------
module mau_datapath #(
  parameter int VALUE_WIDTH = mau_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [VALUE_WIDTH-1:0] modulus,
  input  mau_pkg::request_t      request,
  input  mau_pkg::dp_cmd_t       cmd,
  output mau_pkg::dp_status_t    status,
  output logic [VALUE_WIDTH-1:0] res_value,
  output logic                   res_flag
);

  localparam int W  = VALUE_WIDTH;
  localparam int MC = $clog2(W);

  logic [2:0]   op;
  logic [W-1:0] a_raw;
  logic [63:0]  exp;
  logic [W-1:0] ra, rb, acc, base, r0, r1, t0, t1, q;

  // divider
  logic         div_busy;
  logic [63:0]  dnum, dquo;
  logic [W-1:0] drem, dvs;
  logic [5:0]   dcnt;
  logic [W:0]   dtry;
  logic         dge;

  // multiplier
  logic          mul_busy;
  logic [W-1:0]  mx, my, macc;
  logic [MC-1:0] mcnt;
  logic          mphase;
  logic [W:0]    mdbl, msum, mdbl_red, msum_red;

  logic [W:0]   add_sum;
  logic [W-1:0] sub_res;
  logic         quo_is_m;

  assign dtry = {drem, dnum[63]};
  assign dge  = dtry >= {1'b0, dvs};

  assign mdbl     = {macc, 1'b0};
  assign mdbl_red = (mdbl >= {1'b0, modulus}) ? mdbl - {1'b0, modulus} : mdbl;
  assign msum     = {1'b0, macc} + {1'b0, mx};
  assign msum_red = (msum >= {1'b0, modulus}) ? msum - {1'b0, modulus} : msum;

  assign add_sum  = {1'b0, ra} + {1'b0, rb};
  assign quo_is_m = (dquo[63:W] == '0) && (dquo[W-1:0] == modulus);

  always_comb begin
    if (cmd.act == mau_pkg::ACT_SUB) begin
      sub_res = (ra >= rb) ? ra - rb : modulus - (rb - ra);
    end else begin
      sub_res = (t0 >= macc) ? t0 - macc : modulus - (macc - t0);
    end
  end

  // divider: restoring, one quotient bit a cycle over 64 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && dcnt == 6'd63) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      drem <= '0;
      dquo <= '0;
      dcnt <= '0;
      unique case (cmd.div_sel)
        mau_pkg::DIV_A: begin
          dnum <= 64'(a_raw);
          dvs  <= modulus;
        end
        mau_pkg::DIV_B: begin
          dnum <= exp;
          dvs  <= modulus;
        end
        default: begin
          dnum <= 64'(r0);
          dvs  <= r1;
        end
      endcase
    end else if (div_busy) begin
      drem <= dge ? W'(dtry - {1'b0, dvs}) : dtry[W-1:0];
      dquo <= {dquo[62:0], dge};
      dnum <= {dnum[62:0], 1'b0};
      dcnt <= dcnt + 6'd1;
    end
  end

  // multiplier: msb first, a doubling phase then a conditional-add phase for each bit
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
    end else if (cmd.mul_start) begin
      mul_busy <= 1'b1;
    end else if (mul_busy && mphase && mcnt == MC'(W - 1)) begin
      mul_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      macc   <= '0;
      mcnt   <= '0;
      mphase <= 1'b0;
      unique case (cmd.mul_sel)
        mau_pkg::MUL_AB: begin
          mx <= ra;
          my <= rb;
        end
        mau_pkg::MUL_ACC_BASE: begin
          mx <= base;
          my <= acc;
        end
        mau_pkg::MUL_BASE_BASE: begin
          mx <= base;
          my <= base;
        end
        default: begin
          mx <= t1;
          my <= q;
        end
      endcase
    end else if (mul_busy) begin
      mphase <= ~mphase;
      if (!mphase) begin
        macc <= mdbl_red[W-1:0];
      end else begin
        if (my[W-1]) begin
          macc <= msum_red[W-1:0];
        end
        my   <= {my[W-2:0], 1'b0};
        mcnt <= mcnt + MC'(1);
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= request.operation;
      a_raw <= request.operand_a[W-1:0];
      exp   <= request.operand_b;
    end
    case (cmd.act)
      mau_pkg::ACT_STORE_A: ra <= drem;
      mau_pkg::ACT_STORE_B: rb <= drem;
      mau_pkg::ACT_ADD: begin
        res_value <= (add_sum >= {1'b0, modulus}) ? W'(add_sum - {1'b0, modulus})
                                                  : add_sum[W-1:0];
        res_flag  <= 1'b0;
      end
      mau_pkg::ACT_SUB: begin
        res_value <= sub_res;
        res_flag  <= 1'b0;
      end
      mau_pkg::ACT_MUL_RES: begin
        res_value <= macc;
        res_flag  <= 1'b0;
      end
      mau_pkg::ACT_POW_INIT: begin
        acc  <= W'(1);
        base <= ra;
      end
      mau_pkg::ACT_POW_ACC: acc <= macc;
      mau_pkg::ACT_POW_BASE: begin
        base <= macc;
        exp  <= {1'b0, exp[63:1]};
      end
      mau_pkg::ACT_POW_FIN: begin
        res_value <= acc;
        res_flag  <= 1'b0;
      end
      mau_pkg::ACT_INV_INIT: begin
        r0 <= modulus;
        r1 <= ra;
        t0 <= '0;
        t1 <= W'(1);
      end
      // quotient never exceeds the modulus here
      mau_pkg::ACT_INV_Q: q <= quo_is_m ? '0 : dquo[W-1:0];
      mau_pkg::ACT_INV_STEP: begin
        r0 <= r1;
        r1 <= drem;
        t0 <= t1;
        t1 <= sub_res;
      end
      mau_pkg::ACT_INV_FIN: begin
        res_value <= (r0 == W'(1)) ? t0 : '0;
        res_flag  <= (r0 != W'(1));
      end
      mau_pkg::ACT_ZERO: begin
        res_value <= '0;
        res_flag  <= 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    status.div_busy = div_busy;
    status.mul_busy = mul_busy;
    status.op       = op;
    status.m_small  = modulus < W'(2);
    status.exp_zero = exp == '0;
    status.exp_lsb  = exp[0];
    status.r1_zero  = r1 == '0;
  end

endmodule

>>> sv/mau_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_controller
// sequencer that drives the datapath through each operation
// ----------------------------------------------------------------------------
module mau_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mau_pkg::dp_status_t status,
  output mau_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                done
);

  typedef enum logic [18:0] {
    S_IDLE       = 19'd1 << 0,
    S_RED_A_W    = 19'd1 << 1,
    S_DISPATCH   = 19'd1 << 2,
    S_RED_B      = 19'd1 << 3,
    S_RED_B_W    = 19'd1 << 4,
    S_ARITH      = 19'd1 << 5,
    S_MUL        = 19'd1 << 6,
    S_MUL_W      = 19'd1 << 7,
    S_POW_TEST   = 19'd1 << 8,
    S_POW_ACC_W  = 19'd1 << 9,
    S_POW_BASE   = 19'd1 << 10,
    S_POW_BASE_W = 19'd1 << 11,
    S_INV_TEST   = 19'd1 << 12,
    S_INV_DIV_W  = 19'd1 << 13,
    S_INV_MUL    = 19'd1 << 14,
    S_INV_MUL_W  = 19'd1 << 15,
    S_DONE       = 19'd1 << 16,
    S_SPARE_A    = 19'd1 << 17,
    S_SPARE_B    = 19'd1 << 18
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = mau_pkg::DIV_A;
    cmd.mul_start = 1'b0;
    cmd.mul_sel   = mau_pkg::MUL_AB;
    cmd.act       = mau_pkg::ACT_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SPARE_A;
        end
      end
      // issue reduction of operand a once it is captured
      S_SPARE_A: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = mau_pkg::DIV_A;
        state_next    = S_RED_A_W;
      end
      S_RED_A_W: begin
        if (!status.div_busy) begin
          cmd.act    = mau_pkg::ACT_STORE_A;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.m_small) begin
          cmd.act    = mau_pkg::ACT_ZERO;
          state_next = S_DONE;
        end else begin
          unique case (status.op) inside
            mau_pkg::OP_ADD, mau_pkg::OP_SUB, mau_pkg::OP_MUL: state_next = S_RED_B;
            mau_pkg::OP_POW: begin
              cmd.act    = mau_pkg::ACT_POW_INIT;
              state_next = S_POW_TEST;
            end
            mau_pkg::OP_INV: begin
              cmd.act    = mau_pkg::ACT_INV_INIT;
              state_next = S_INV_TEST;
            end
            default: begin
              cmd.act    = mau_pkg::ACT_ZERO;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_RED_B: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = mau_pkg::DIV_B;
        state_next    = S_RED_B_W;
      end
      S_RED_B_W: begin
        if (!status.div_busy) begin
          cmd.act    = mau_pkg::ACT_STORE_B;
          state_next = S_ARITH;
        end
      end
      S_ARITH: begin
        if (status.op == mau_pkg::OP_ADD) begin
          cmd.act    = mau_pkg::ACT_ADD;
          state_next = S_DONE;
        end else if (status.op == mau_pkg::OP_SUB) begin
          cmd.act    = mau_pkg::ACT_SUB;
          state_next = S_DONE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = mau_pkg::MUL_AB;
        state_next    = S_MUL_W;
      end
      S_MUL_W: begin
        if (!status.mul_busy) begin
          cmd.act    = mau_pkg::ACT_MUL_RES;
          state_next = S_DONE;
        end
      end
      S_POW_TEST: begin
        if (status.exp_zero) begin
          cmd.act    = mau_pkg::ACT_POW_FIN;
          state_next = S_DONE;
        end else if (status.exp_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = mau_pkg::MUL_ACC_BASE;
          state_next    = S_POW_ACC_W;
        end else begin
          state_next = S_POW_BASE;
        end
      end
      S_POW_ACC_W: begin
        if (!status.mul_busy) begin
          cmd.act    = mau_pkg::ACT_POW_ACC;
          state_next = S_POW_BASE;
        end
      end
      S_POW_BASE: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = mau_pkg::MUL_BASE_BASE;
        state_next    = S_POW_BASE_W;
      end
      S_POW_BASE_W: begin
        if (!status.mul_busy) begin
          cmd.act    = mau_pkg::ACT_POW_BASE;
          state_next = S_POW_TEST;
        end
      end
      S_INV_TEST: begin
        if (status.r1_zero) begin
          cmd.act    = mau_pkg::ACT_INV_FIN;
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = mau_pkg::DIV_R;
          state_next    = S_INV_DIV_W;
        end
      end
      S_INV_DIV_W: begin
        if (!status.div_busy) begin
          cmd.act    = mau_pkg::ACT_INV_Q;
          state_next = S_INV_MUL;
        end
      end
      S_INV_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = mau_pkg::MUL_Q_T1;
        state_next    = S_INV_MUL_W;
      end
      S_INV_MUL_W: begin
        if (!status.mul_busy) begin
          cmd.act    = mau_pkg::ACT_INV_STEP;
          state_next = S_INV_TEST;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule
